@@ sv/casa_pkg.sv @@
// Shared types, constants and the positive single-precision add for the
// checked absolute-value sum block. No dependencies.
package casa_pkg;

  localparam int LenW      = 24;
  localparam int FpW       = 32;
  localparam int LaneCount = 64;
  localparam int LaneW     = 6;
  localparam logic [FpW-1:0] PosInf = 32'h7F80_0000;

  // controller to datapath commands
  typedef struct packed {
    logic clear;       // clear position, tail and fault count
    logic lane_add;    // accumulate element into its lane
    logic tail_add;    // accumulate element into tail
    logic tree_load;   // start the reduction of the lanes
    logic tree_step;   // reduction step command; the datapath does not use it
  } casa_cmd_t;

  typedef struct packed {
    logic last_elem;   // current element is the last of the job
    logic last_whole;  // current element closes the last whole block
    logic in_blocks;   // current element falls in a whole block
    logic tree_done;   // reduction finished
  } casa_sts_t;

  function automatic logic is_nan(input logic [FpW-1:0] v);
    return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
  endfunction

  // Add two non-negative values, round to nearest even, subnormals kept.
  function automatic logic [FpW-1:0] fadd_pos(input logic [FpW-1:0] a_in,
                                              input logic [FpW-1:0] b_in);
    logic [30:0] a, b, t;
    logic [7:0]  ea, eb;
    logic [8:0]  e;
    logic [26:0] ma, mb, sh;
    logic [27:0] sum;
    logic [24:0] m;
    logic [7:0]  d;
    logic        sticky;
    logic [FpW-1:0] res;
    a = a_in[30:0];
    b = b_in[30:0];
    if (b > a) begin
      t = a; a = b; b = t;
    end
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {(a[30:23] != 8'd0), a[22:0], 3'b000};
    mb = {(b[30:23] != 8'd0), b[22:0], 3'b000};
    d = ea - eb;
    if (d >= 8'd27) begin
      sh = {26'd0, (mb != 27'd0)};
    end else begin
      sh = mb >> d;
      sticky = ((mb & ((27'd1 << d) - 27'd1)) != 27'd0);
      sh[0] = sh[0] | sticky;
    end
    sum = {1'b0, ma} + {1'b0, sh};
    e = {1'b0, ea};
    if (sum[27]) begin
      sum = {1'b0, sum[27:1]} | {27'd0, sum[0]};
      e = e + 9'd1;
    end
    m = {1'b0, sum[26:3]};
    if (sum[2] && (sum[1:0] != 2'd0 || m[0])) m = m + 25'd1;
    if (m[24]) begin
      m = m >> 1;
      e = e + 9'd1;
    end
    if (is_nan(a_in)) res = a_in | 32'h0040_0000;
    else if (is_nan(b_in)) res = b_in | 32'h0040_0000;
    else if (a_in[30:23] == 8'hFF || b_in[30:23] == 8'hFF) res = PosInf;
    else if (e >= 9'd255) res = PosInf;
    else res = {1'b0, (m[23] ? e[7:0] : 8'd0), m[22:0]};
    return res;
  endfunction

endpackage

@@ sv/casa_ram.sv @@
// Generic single-port-write, registered-read RAM.
// No dependencies.
module casa_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ sv/casa_dp.sv @@
// Datapath: lane memory, checked adder, reduction sequencer and tail.
// Depends on casa_pkg and casa_ram.
module casa_dp
  import casa_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  casa_cmd_t       cmd,
  input  logic [LenW-1:0] vector_length,
  input  logic [FpW-1:0]  value_bits,
  output casa_sts_t       sts,
  output logic [FpW-1:0]  sum_bits,
  output logic [LenW-1:0] fault_count
);
  localparam int TreeLast = LaneCount - 2;
  localparam logic [1:0] PhA = 2'd0, PhB = 2'd1, PhAdd = 2'd2;

  logic [LenW-1:0]      pos;
  logic [LenW-1:0]      whole;
  logic [LaneW-1:0]     lane;
  logic [LaneCount-1:0] lane_valid;
  logic [FpW-1:0]       rdata, lane_old, x;
  logic                 we;
  logic [LaneW-1:0]     waddr, raddr;
  logic [FpW-1:0]       wdata;

  // reduction: each add reads both operands from the lane memory, then writes back
  logic             tbusy;
  logic [LaneW-1:0] tstep;
  logic [1:0]       tph;
  logic [FpW-1:0]   opa;
  logic [LaneW-1:0] ta_idx, tb_idx, td_idx;
  logic             tree_add;

  logic [FpW-1:0] tail;
  logic [FpW-1:0] add_a, add_b, r1, r2;

  assign whole = vector_length & ~LenW'(LaneCount - 1);
  assign lane  = pos[LaneW-1:0];
  assign x     = {1'b0, value_bits[30:0]};
  assign sts.last_elem  = (LenW + 1)'(pos) + 1'b1 >= {1'b0, vector_length};
  assign sts.in_blocks  = pos < whole;
  assign sts.last_whole = (LenW + 1)'(pos) + 1'b1 == {1'b0, whole};

  // lane memory: read current lane ahead; cmd arrives with the registered data
  casa_ram #(.Width(FpW), .Depth(LaneCount)) u_lanes (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );
  assign lane_old = lane_valid[lane] ? rdata : '0;

  // tree schedule: lane pairs 16 apart and 48/32, then 32, 8, 4 apart,
  // then y0+y1, y2+y3 and their sum
  always_comb begin
    ta_idx = '0;
    tb_idx = '0;
    td_idx = '0;
    if (tstep < 6'd16) begin
      ta_idx = tstep + 6'd16;
      tb_idx = tstep;
      td_idx = tstep;
    end else if (tstep < 6'd32) begin
      ta_idx = tstep + 6'd32;
      tb_idx = tstep + 6'd16;
      td_idx = tstep + 6'd16;
    end else if (tstep < 6'd48) begin
      ta_idx = tstep;
      tb_idx = tstep - 6'd32;
      td_idx = tstep - 6'd32;
    end else if (tstep < 6'd56) begin
      ta_idx = tstep - 6'd40;
      tb_idx = tstep - 6'd48;
      td_idx = tstep - 6'd48;
    end else if (tstep < 6'd60) begin
      ta_idx = tstep - 6'd52;
      tb_idx = tstep - 6'd56;
      td_idx = tstep - 6'd56;
    end else if (tstep == 6'd60) begin
      ta_idx = 6'd0;
      tb_idx = 6'd1;
      td_idx = 6'd0;
    end else if (tstep == 6'd61) begin
      ta_idx = 6'd2;
      tb_idx = 6'd3;
      td_idx = 6'd2;
    end else begin
      ta_idx = 6'd0;
      tb_idx = 6'd2;
      td_idx = 6'd0;
    end
  end

  assign tree_add = tbusy && tph == PhAdd;
  assign raddr = !tbusy ? lane : ((tph == PhA) ? ta_idx : tb_idx);

  // duplicated adder and compare
  always_comb begin
    add_a = tail;
    add_b = x;
    if (cmd.lane_add) add_a = lane_old;
    if (tbusy) begin
      add_a = opa;
      add_b = rdata;
    end
    r1 = fadd_pos(add_a, add_b);
    r2 = fadd_pos(add_a, add_b);
  end

  assign we    = cmd.lane_add || tree_add;
  assign waddr = tbusy ? td_idx : lane;
  assign wdata = r1;

  assign sts.tree_done = tree_add && tstep == LaneW'(TreeLast);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      pos <= '0;
      tail <= '0;
      fault_count <= '0;
      lane_valid <= '0;
      tbusy <= 1'b0;
      tstep <= '0;
      tph <= PhA;
    end else begin
      if (cmd.lane_add || cmd.tail_add) pos <= pos + 1'b1;
      if (cmd.lane_add) lane_valid[lane] <= 1'b1;
      if (cmd.tail_add) tail <= r1;
      if (r1 != r2 && (cmd.lane_add || cmd.tail_add || tree_add) &&
          fault_count != '1) fault_count <= fault_count + 1'b1;
      if (cmd.tree_load) begin
        tbusy <= 1'b1;
        tstep <= '0;
        tph <= PhA;
      end else if (tbusy) begin
        // read first operand, read second, then add and write back
        case (tph)
          PhA: tph <= PhB;
          PhB: begin
            opa <= rdata;
            tph <= PhAdd;
          end
          default: begin
            tph <= PhA;
            if (tstep == LaneW'(TreeLast)) begin
              tail <= r1;
              tbusy <= 1'b0;
            end else tstep <= tstep + 1'b1;
          end
        endcase
      end
    end
  end

  assign sum_bits = tail;
endmodule

@@ sv/casa_ctrl.sv @@
// Controller state machine for the checked absolute-value sum.
// Depends on casa_pkg.
module casa_ctrl
  import casa_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            cfg_wr,
  input  logic [LenW-1:0] vector_length,
  input  casa_sts_t       sts,
  output logic            busy,
  output logic            done,
  output casa_cmd_t       cmd
);
  localparam logic [1:0] Idle = 2'd0, Read = 2'd1, Tree = 2'd2, Emit = 2'd3;
  logic [1:0] state, state_next;
  logic       fin, fin_next;

  assign busy = state != Idle;

  // sequence each element: lane read, add, optional reduction, result
  always_comb begin
    state_next = state;
    fin_next = fin;
    cmd = '0;
    done = 1'b0;
    unique case (state)
      Idle: if (start && vector_length != '0) state_next = Read;
      Read: begin
        if (sts.in_blocks) cmd.lane_add = 1'b1;
        else cmd.tail_add = 1'b1;
        fin_next = sts.last_elem;
        if (sts.in_blocks && sts.last_whole) begin
          cmd.tree_load = 1'b1;
          state_next = Tree;
        end else state_next = sts.last_elem ? Emit : Idle;
      end
      Tree: if (sts.tree_done) state_next = fin ? Emit : Idle;
      Emit: begin
        done = 1'b1;
        cmd.clear = 1'b1;
        state_next = Idle;
      end
      default: state_next = Idle;
    endcase
    if (cfg_wr) cmd.clear = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= Idle;
      fin <= 1'b0;
    end else begin
      state <= state_next;
      fin <= fin_next;
    end
  end
endmodule

@@ sv/checked_abs_sum_accumulator_top.sv @@
// Top level of the checked absolute-value sum: APB register, controller,
// datapath. Depends on casa_pkg, casa_ctrl, casa_dp.
//
// Usage: write vector_length at address 0 over APB (this clears the job).
// Then send elements one per transaction: start high while busy is low.
// After the accepting edge busy is high for one add cycle, so a new element
// is taken only after the lane read and add of the last one. The element
// that closes the last whole 64-element block then runs 63 reduction adds,
// each two lane memory reads, then add and write-back, with busy held high.
// After the last element, sum_bits and fault_count are shown for one cycle
// with done high, in the Emit state that follows the add or the reduction;
// the job state is then cleared and busy stays high through that cycle.
// A zero length ignores elements. Reset clears the length and all job state.
// The receiver cannot stall; results must be taken in the cycle they are
// shown.
module checked_abs_sum_accumulator_top
  import casa_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [0:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  input  logic            start,
  output logic            busy,
  input  logic [31:0]     value_bits,
  output logic            done,
  output logic [31:0]     sum_bits,
  output logic [23:0]     fault_count
);
  logic [LenW-1:0] vector_length;
  logic            cfg_wr;
  casa_cmd_t       cmd;
  casa_sts_t       sts;
  logic [FpW-1:0]  val_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && paddr == 1'b0;
  assign prdata = (paddr == 1'b0) ? {8'd0, vector_length} : '0;

  // hold the length register and capture the element
  always_ff @(posedge clk) begin
    if (rst) vector_length <= '0;
    else if (cfg_wr) vector_length <= pwdata[LenW-1:0];
    if (start && !busy) val_q <= value_bits;
  end

  casa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .cfg_wr(cfg_wr),
    .vector_length(vector_length), .sts(sts), .busy(busy), .done(done), .cmd(cmd)
  );

  casa_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .vector_length(vector_length),
    .value_bits(val_q), .sts(sts), .sum_bits(sum_bits), .fault_count(fault_count)
  );

`ifndef SYNTHESIS
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result shown while idle");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result held over two cycles");
  a_no_fault: assert property (@(posedge clk) disable iff (rst)
    done |-> fault_count == '0)
    else $error("adder mismatch seen");
`endif
endmodule
